// ----- sv/assert_macros.svh -----
// Assertion macros shared by the frame encoder RTL.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/fec_pkg.sv -----
// Types, constants and the CRC step function of the frame encoder.
// No dependencies; used by every RTL module of the block.
package fec_pkg;

  localparam logic MODE_HEADER  = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_SYNC_FIRST    = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND   = 3'd1;
  localparam logic [2:0] REG_ACCEPTED_VER  = 3'd2;
  localparam logic [2:0] REG_KIND_REQUEST  = 3'd3;
  localparam logic [2:0] REG_KIND_RESPONSE = 3'd4;
  localparam logic [2:0] REG_KIND_REPORT   = 3'd5;
  localparam logic [2:0] REG_KIND_ERROR    = 3'd6;
  localparam logic [2:0] REG_MAX_LEN       = 3'd7;

  localparam logic [16:0] FRAME_OVERHEAD = 17'd10;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_TYPE    = 3'd2,
    ST_TOO_LARGE   = 3'd3,
    ST_TOO_SMALL   = 3'd4,
    ST_STRAY       = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_ERR  = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_DATA = 2'd2
  } cmd_kind_t;

  // one classified transaction, handed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;
    logic        close;       // CRC follows this command
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  version;
    logic [7:0]  frame_kind;
    logic [15:0] sequence_number;
    logic [15:0] payload_count;
    logic [7:0]  data_byte;
    logic [16:0] total;
  } cmd_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- sv/fec_front.sv -----
// Front end: configuration registers, header checks and frame tracking.
// Turns each accepted input transaction into one command; uses fec_pkg.
module fec_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          push,
  input  logic          mode,
  input  logic [7:0]    frame_version,
  input  logic [7:0]    frame_kind,
  input  logic [15:0]   sequence_number,
  input  logic [15:0]   payload_count,
  input  logic [16:0]   capacity,
  input  logic [7:0]    data_byte,
  input  logic          q_full,
  output logic          q_push,
  output fec_pkg::cmd_t q_cmd
);
  import fec_pkg::*;

  logic [7:0]  sync_first, sync_second, accepted_version;
  logic [7:0]  kind_request, kind_response, kind_report, kind_error;
  logic [15:0] max_payload_length;

  logic        in_frame, in_frame_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [16:0] frame_total, frame_total_next;

  logic        kind_ok;
  logic [16:0] need;
  status_t     hdr_status;

  assign q_push  = push & ~q_full;
  assign kind_ok = (frame_kind == kind_request) || (frame_kind == kind_response) ||
                   (frame_kind == kind_report)  || (frame_kind == kind_error);
  assign need    = {1'b0, payload_count} + FRAME_OVERHEAD;

  always_comb begin
    hdr_status = ST_OK;
    if (frame_version != accepted_version)      hdr_status = ST_BAD_VERSION;
    else if (!kind_ok)                          hdr_status = ST_BAD_TYPE;
    else if (payload_count > max_payload_length) hdr_status = ST_TOO_LARGE;
    else if (capacity < need)                   hdr_status = ST_TOO_SMALL;
  end

  always_comb begin
    q_cmd                 = '0;
    q_cmd.sync_first      = sync_first;
    q_cmd.sync_second     = sync_second;
    q_cmd.version         = frame_version;
    q_cmd.frame_kind      = frame_kind;
    q_cmd.sequence_number = sequence_number;
    q_cmd.payload_count   = payload_count;
    q_cmd.data_byte       = data_byte;
    in_frame_next         = in_frame;
    bytes_left_next       = bytes_left;
    frame_total_next      = frame_total;
    if (mode == MODE_HEADER) begin
      if (hdr_status != ST_OK) begin
        q_cmd.kind      = CMD_ERR;
        q_cmd.status    = hdr_status;
        in_frame_next   = 1'b0;
        bytes_left_next = '0;
      end else begin
        q_cmd.kind       = CMD_HDR;
        q_cmd.status     = ST_OK;
        q_cmd.close      = (payload_count == 16'd0);
        q_cmd.total      = need;
        frame_total_next = need;
        bytes_left_next  = payload_count;
        in_frame_next    = (payload_count != 16'd0);
      end
    end else if (!in_frame || bytes_left == 16'd0) begin
      q_cmd.kind    = CMD_ERR;
      q_cmd.status  = ST_STRAY;
      in_frame_next = 1'b0;
    end else begin
      q_cmd.kind      = CMD_DATA;
      q_cmd.status    = ST_OK;
      q_cmd.close     = (bytes_left == 16'd1);
      q_cmd.total     = frame_total;
      bytes_left_next = bytes_left - 16'd1;
      in_frame_next   = (bytes_left != 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first         <= 8'hAA;
      sync_second        <= 8'h55;
      accepted_version   <= 8'd1;
      kind_request       <= 8'd1;
      kind_response      <= 8'd2;
      kind_report        <= 8'd3;
      kind_error         <= 8'd4;
      max_payload_length <= 16'd1024;
      in_frame           <= 1'b0;
      bytes_left         <= '0;
      frame_total        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_FIRST:    sync_first         <= cfg_data[7:0];
          REG_SYNC_SECOND:   sync_second        <= cfg_data[7:0];
          REG_ACCEPTED_VER:  accepted_version   <= cfg_data[7:0];
          REG_KIND_REQUEST:  kind_request       <= cfg_data[7:0];
          REG_KIND_RESPONSE: kind_response      <= cfg_data[7:0];
          REG_KIND_REPORT:   kind_report        <= cfg_data[7:0];
          REG_KIND_ERROR:    kind_error         <= cfg_data[7:0];
          REG_MAX_LEN:       max_payload_length <= cfg_data;
          default: ;
        endcase
      end
      if (q_push) begin
        in_frame    <= in_frame_next;
        bytes_left  <= bytes_left_next;
        frame_total <= frame_total_next;
      end
    end
  end

endmodule

// ----- sv/fec_queue.sv -----
// Command queue between front and back, DEPTH entries of fec_pkg::cmd_t.
// Uses fec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fec_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  fec_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output logic          head_valid,
  output fec_pkg::cmd_t head
);
  import fec_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_wr      = wr_en & ~full;
  assign do_rd      = rd_en & head_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_CLK(a_no_write_when_full, !(wr_en && full), "command written into full queue")
  `ASSERT_RST(a_empty_after_reset, rst |=> (count == '0) && !head_valid, "queue not empty after reset")

endmodule

// ----- sv/fec_back.sv -----
// Back end: steps through each command, one result per cycle while the result
// register is free or being popped, keeps the CRC and holds that register. Uses fec_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fec_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  fec_pkg::cmd_t head,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic [2:0]    status,
  output logic          last,
  output logic [16:0]   encoded_total
);
  import fec_pkg::*;

  localparam logic [3:0] HDR_LEN_LO = 4'd7;
  localparam logic [3:0] HDR_CRC_HI = 4'd8;
  localparam logic [3:0] HDR_CRC_LO = 4'd9;
  localparam logic [3:0] DAT_CRC_HI = 4'd1;
  localparam logic [3:0] DAT_CRC_LO = 4'd2;

  logic [3:0]  step;
  logic [15:0] crc, crc_next;
  logic        out_valid, advance, done, upd;

  logic [7:0]  r_byte;
  logic        r_valid, r_last;
  status_t     r_status, out_status;
  logic [16:0] r_total;

  assign empty   = ~out_valid;
  assign status  = out_status;
  assign advance = head_valid & (~out_valid | pop);
  assign q_pop   = advance & done;

  always_comb begin
    r_byte   = '0;
    r_valid  = 1'b1;
    r_status = ST_OK;
    r_last   = 1'b0;
    r_total  = '0;
    done     = 1'b0;
    upd      = 1'b0;
    crc_next = crc;
    case (head.kind)
      CMD_ERR: begin
        r_valid  = 1'b0;
        r_status = head.status;
        r_last   = 1'b1;
        done     = 1'b1;
      end
      CMD_HDR: begin
        case (step)
          4'd0: begin
            r_byte   = head.sync_first;
            crc_next = CRC_INIT;
          end
          4'd1: r_byte = head.sync_second;
          4'd2: begin r_byte = head.version;               upd = 1'b1; end
          4'd3: begin r_byte = head.frame_kind;            upd = 1'b1; end
          4'd4: begin r_byte = head.sequence_number[15:8]; upd = 1'b1; end
          4'd5: begin r_byte = head.sequence_number[7:0];  upd = 1'b1; end
          4'd6: begin r_byte = head.payload_count[15:8];   upd = 1'b1; end
          HDR_LEN_LO: begin
            r_byte = head.payload_count[7:0];
            upd    = 1'b1;
            r_last = ~head.close;
            done   = ~head.close;
          end
          HDR_CRC_HI: r_byte = crc[15:8];
          HDR_CRC_LO: begin
            r_byte  = crc[7:0];
            r_last  = 1'b1;
            r_total = head.total;
            done    = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
      CMD_DATA: begin
        case (step)
          4'd0: begin
            r_byte = head.data_byte;
            upd    = 1'b1;
            r_last = ~head.close;
            done   = ~head.close;
          end
          DAT_CRC_HI: r_byte = crc[15:8];
          DAT_CRC_LO: begin
            r_byte  = crc[7:0];
            r_last  = 1'b1;
            r_total = head.total;
            done    = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
      default: done = 1'b1;
    endcase
    if (upd) crc_next = crc_update(crc, r_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
      crc       <= CRC_INIT;
    end else if (advance) begin
      out_valid <= 1'b1;
      crc       <= crc_next;
      step      <= done ? 4'd0 : step + 4'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte      <= r_byte;
      byte_valid    <= r_valid;
      out_status    <= r_status;
      last          <= r_last;
      encoded_total <= r_total;
    end
  end

  `ASSERT_CLK(a_total_on_crc, out_valid && (encoded_total != 17'd0) |-> last && byte_valid, "frame total off the final CRC byte")
  `ASSERT_CLK(a_error_no_byte, out_valid && (out_status != ST_OK) |-> !byte_valid && last, "error result carries a byte")
  `ASSERT_CLK(a_step_needs_cmd, (step != 4'd0) |-> head_valid, "sequencer mid-command with no command")
  `ASSERT_CLK(a_step_bound, head_valid && (head.kind == CMD_HDR) |-> (step <= HDR_CRC_LO), "header step out of range")

endmodule

// ----- sv/frame_encoder_crc16_core.sv -----
// Framed packet encoder, CRC-16/CCITT-FALSE over version through payload.
// An accepted input transaction is written into the command queue; its first result then goes to the result register.
// Results per command: header 8 (10 with empty payload), payload byte 1 (3 when
// it closes the frame), error 1; the back sequencer makes one result a cycle unless the output is held.
// Reset (rst, sync, active high): registers to defaults, queue and output empty.
module frame_encoder_crc16_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input transactions
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  frame_version,
  input  logic [7:0]  frame_kind,
  input  logic [15:0] sequence_number,
  input  logic [15:0] payload_count,
  input  logic [16:0] capacity,
  input  logic [7:0]  data_byte,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic [2:0]  status,
  output logic        last,
  output logic [16:0] encoded_total
);
  import fec_pkg::*;

  // Front classifies each transaction into a command: header error, header,
  // payload byte or stray payload. Frame state (open, bytes left, total)
  // lives there so the next transaction can be classified at once.
  logic q_push, q_full, q_pop, head_valid;
  cmd_t q_cmd, head;

  fec_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .mode            (mode),
    .frame_version   (frame_version),
    .frame_kind      (frame_kind),
    .sequence_number (sequence_number),
    .payload_count   (payload_count),
    .capacity        (capacity),
    .data_byte       (data_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  // Input side stalls only when the command queue is full.
  assign full = q_full;

  // Short queue decouples the front from the multi-result back sequencer.
  fec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (q_push),
    .wr_cmd     (q_cmd),
    .full       (q_full),
    .rd_en      (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back expands each command into frame bytes, keeps the running CRC and
  // owns the result register; it advances whenever it has a command and that register
  // is free or being popped in the same cycle.
  fec_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .status        (status),
    .last          (last),
    .encoded_total (encoded_total)
  );

endmodule

// ----- test/tb_frame_encoder_crc16_core.sv -----
// Testbench for frame_encoder_crc16_core: directed and random frames checked
// against a cycle-free encoder model. Depends on fec_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_frame_encoder_crc16_core;
  import fec_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no transaction on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block up

  // one input transaction as offered on the ports
  typedef struct {
    logic        mode;
    logic [7:0]  version;
    logic [7:0]  kind;
    logic [15:0] seq;
    logic [15:0] count;
    logic [16:0] cap;
    logic [7:0]  data;
  } frame_item_t;

  // one result transaction as it should leave the block
  typedef struct {
    logic [7:0]  octet;
    logic        valid;
    status_t     code;
    logic        tail;
    logic [16:0] total;
  } frame_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_SYNC_FIRST;
  logic [15:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic        mode = MODE_HEADER;
  logic [7:0]  frame_version = '0;
  logic [7:0]  frame_kind = '0;
  logic [15:0] sequence_number = '0;
  logic [15:0] payload_count = '0;
  logic [16:0] capacity = '0;
  logic [7:0]  data_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [2:0]  status;
  logic        last;
  logic [16:0] encoded_total;

  frame_encoder_crc16_core i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .push, .full, .mode, .frame_version, .frame_kind, .sequence_number,
    .payload_count, .capacity, .data_byte,
    .empty, .pop, .out_byte, .byte_valid, .status, .last, .encoded_total
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register copy and encoder state of the model
  logic [15:0] reg_shadow [8];
  logic [15:0] reg_plan [8];
  logic        enc_open = 1'b0;
  logic [15:0] enc_left = '0;
  logic [15:0] enc_crc = 16'hFFFF;
  logic [16:0] enc_total = '0;

  frame_item_t pending_items [$];
  frame_out_t  frame_bytes_due [$];
  frame_item_t on_wire;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned error_count = 0;
  bit          quiet = 1'b0;          // no idling on either side
  bit          pressure_req = 1'b0;

  // CRC-16/CCITT-FALSE, bit-serial form, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic bit is_kind(input logic [7:0] k);
    return k == reg_shadow[REG_KIND_REQUEST][7:0] || k == reg_shadow[REG_KIND_RESPONSE][7:0] ||
           k == reg_shadow[REG_KIND_REPORT][7:0] || k == reg_shadow[REG_KIND_ERROR][7:0];
  endfunction

  task automatic expect_result(input logic [7:0] octet, input logic valid, input status_t code,
                               input logic tail, input logic [16:0] total);
    frame_out_t r;
    r.octet = octet;
    r.valid = valid;
    r.code  = code;
    r.tail  = tail;
    r.total = total;
    frame_bytes_due.push_back(r);
  endtask

  // a byte covered by the CRC
  task automatic emit_body(input logic [7:0] b);
    enc_crc = crc16_step(enc_crc, b);
    expect_result(b, 1'b1, ST_OK, 1'b0, '0);
  endtask

  task automatic emit_crc_pair();
    expect_result(enc_crc[15:8], 1'b1, ST_OK, 1'b0, '0);
    expect_result(enc_crc[7:0], 1'b1, ST_OK, 1'b1, enc_total);
    enc_open = 1'b0;
    enc_left = '0;
  endtask

  task automatic mark_tail();
    frame_bytes_due[frame_bytes_due.size() - 1].tail = 1'b1;
  endtask

  // expected result transactions of one accepted input transaction
  task automatic encode_transaction(input frame_item_t it);
    status_t code;
    if (it.mode == MODE_HEADER) begin
      code = ST_OK;
      if (it.version != reg_shadow[REG_ACCEPTED_VER][7:0]) code = ST_BAD_VERSION;
      else if (!is_kind(it.kind)) code = ST_BAD_TYPE;
      else if (it.count > reg_shadow[REG_MAX_LEN]) code = ST_TOO_LARGE;
      else if (it.cap < FRAME_OVERHEAD + {1'b0, it.count}) code = ST_TOO_SMALL;
      if (code != ST_OK) begin
        // rejected header also drops any open frame
        enc_open = 1'b0;
        enc_left = '0;
        expect_result(8'h00, 1'b0, code, 1'b1, '0);
      end else begin
        // a header on an open frame just restarts; the old one gets no CRC
        enc_crc   = CRC_INIT;
        enc_total = FRAME_OVERHEAD + {1'b0, it.count};
        enc_left  = it.count;
        enc_open  = 1'b1;
        expect_result(reg_shadow[REG_SYNC_FIRST][7:0], 1'b1, ST_OK, 1'b0, '0);
        expect_result(reg_shadow[REG_SYNC_SECOND][7:0], 1'b1, ST_OK, 1'b0, '0);
        emit_body(it.version);
        emit_body(it.kind);
        emit_body(it.seq[15:8]);
        emit_body(it.seq[7:0]);
        emit_body(it.count[15:8]);
        emit_body(it.count[7:0]);
        if (it.count == 0) emit_crc_pair();
        else mark_tail();
      end
    end else if (!enc_open || enc_left == 0) begin
      enc_open = 1'b0;
      expect_result(8'h00, 1'b0, ST_STRAY, 1'b1, '0);
    end else begin
      emit_body(it.data);
      enc_left = enc_left - 16'd1;
      if (enc_left == 0) emit_crc_pair();
      else mark_tail();
    end
  endtask

  function automatic frame_item_t header_item(input logic [7:0] ver, input logic [7:0] kind,
                                              input logic [15:0] seq, input logic [15:0] cnt,
                                              input logic [16:0] cap);
    frame_item_t it;
    it.mode    = MODE_HEADER;
    it.version = ver;
    it.kind    = kind;
    it.seq     = seq;
    it.count   = cnt;
    it.cap     = cap;
    it.data    = 8'($urandom_range(0, 255));  // ignored on headers
    return it;
  endfunction

  function automatic frame_item_t payload_item(input logic [7:0] d);
    frame_item_t it;
    // header fields carry junk, the block must ignore them
    it.mode    = MODE_PAYLOAD;
    it.version = 8'($urandom_range(0, 255));
    it.kind    = 8'($urandom_range(0, 255));
    it.seq     = 16'($urandom_range(0, 65535));
    it.count   = 16'($urandom_range(0, 65535));
    it.cap     = 17'($urandom_range(0, 65545));
    it.data    = d;
    return it;
  endfunction

  task automatic add_item(input frame_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // capacity that fits a frame of len payload bytes, often exactly
  function automatic logic [16:0] fit_cap(input int len);
    if ($urandom_range(0, 2) == 0) return 17'(10 + len);
    return 17'(10 + len + $urandom_range(0, 65535 - len));
  endfunction

  // mostly well-formed frames; some truncated, near-miss headers and noise
  task automatic queue_random(input int n);
    int made, sel, len, sent, fault, max_len;
    logic [7:0] ver, kind;
    made = 0;
    while (made < n) begin
      max_len = int'(reg_shadow[REG_MAX_LEN]);
      sel = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      if (len > max_len) len = max_len;
      ver  = reg_shadow[REG_ACCEPTED_VER][7:0];
      kind = reg_shadow[REG_KIND_REQUEST + $urandom_range(0, 3)][7:0];
      if (sel < 75) begin
        sent = (sel >= 65 && len > 0) ? $urandom_range(0, len - 1) : len;
        add_item(header_item(ver, kind, 16'($urandom_range(0, 65535)), 16'(len),
                             fit_cap(len)));
        for (int i = 0; i < sent; i++) add_item(payload_item(8'($urandom_range(0, 255))));
        made += sent + 1;
      end else if (sel < 87) begin
        fault = $urandom_range(0, 3);
        if (fault == 2 && max_len == 65535) fault = 3;
        case (fault)
          0: ver = ver ^ (8'h01 << $urandom_range(0, 7));
          1: while (is_kind(kind)) kind = 8'($urandom_range(0, 255));
          2: len = $urandom_range(max_len + 1, 65535);
          default: ;
        endcase
        add_item(header_item(ver, kind, 16'($urandom_range(0, 65535)), 16'(len),
                             (fault == 3) ? 17'($urandom_range(0, len + 9)) : fit_cap(len)));
        made++;
      end else if (sel < 94) begin
        add_item(header_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             17'($urandom_range(0, 65545))));
        made++;
      end else begin
        add_item(payload_item(8'($urandom_range(0, 255))));
        made++;
      end
    end
  endtask

  task automatic plan_defaults();
    reg_plan[REG_SYNC_FIRST]    = 16'h00AA;
    reg_plan[REG_SYNC_SECOND]   = 16'h0055;
    reg_plan[REG_ACCEPTED_VER]  = 16'd1;
    reg_plan[REG_KIND_REQUEST]  = 16'd1;
    reg_plan[REG_KIND_RESPONSE] = 16'd2;
    reg_plan[REG_KIND_REPORT]   = 16'd3;
    reg_plan[REG_KIND_ERROR]    = 16'd4;
    reg_plan[REG_MAX_LEN]       = 16'd1024;
  endtask

  // writes all of reg_plan on back-to-back cycles; block must be idle
  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= reg_plan[i];
      reg_shadow[i] = (3'(i) == REG_MAX_LEN) ? reg_plan[i] : {8'h00, reg_plan[i][7:0]};
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle(input int extra);
    while (items_accepted != items_queued || frame_bytes_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // stimulus sequencing: phases separated by idle register writes
  initial begin
    plan_defaults();
    for (int i = 0; i < 8; i++) reg_shadow[i] = reg_plan[i];
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    add_item(payload_item(8'hFF));                          // payload with no frame open
    add_item(header_item(8'd1, 8'd1, 16'hFFFF, 16'd2, 17'd12)); // capacity exactly enough
    add_item(payload_item(8'h00));
    add_item(payload_item(8'hFF));
    add_item(payload_item(8'h3C));                          // payload after frame closed
    add_item(header_item(8'd1, 8'd2, 16'h0000, 16'd0, 17'd10)); // empty payload
    add_item(header_item(8'd0, 8'd1, 16'h0101, 16'd1, 17'd11)); // bad version
    add_item(header_item(8'd1, 8'hFF, 16'h0202, 16'd1, 17'd11)); // bad type
    add_item(header_item(8'd1, 8'd3, 16'h8000, 16'd1025, 17'd65545)); // too large
    add_item(header_item(8'd1, 8'd4, 16'h7FFF, 16'd1024, 17'd1033)); // too small by one
    add_item(header_item(8'd1, 8'd3, 16'h1234, 16'd1024, 17'd65545));
    add_item(payload_item(8'hA5));
    add_item(header_item(8'd1, 8'd4, 16'h5678, 16'd1, 17'd11)); // abandons the open frame
    add_item(payload_item(8'h5A));
    add_item(header_item(8'd1, 8'd1, 16'h00FF, 16'd3, 17'd13));
    add_item(payload_item(8'h81));
    add_item(header_item(8'd2, 8'd1, 16'h0303, 16'd0, 17'd10)); // rejected, closes frame
    add_item(payload_item(8'h18));
    add_item(header_item(8'd1, 8'd2, 16'hAAAA, 16'd5, 17'd15)); // stays open over writes
    add_item(payload_item(8'h7E));
    settle(4);

    // extremes; upper data bits set on 8-bit registers must be dropped
    reg_plan[REG_SYNC_FIRST]    = 16'hFF00;
    reg_plan[REG_SYNC_SECOND]   = 16'hFFFF;
    reg_plan[REG_ACCEPTED_VER]  = 16'h00FF;
    reg_plan[REG_KIND_REQUEST]  = 16'h0000;
    reg_plan[REG_KIND_RESPONSE] = 16'h00FF;
    reg_plan[REG_KIND_REPORT]   = 16'h0080;
    reg_plan[REG_KIND_ERROR]    = 16'h007F;
    reg_plan[REG_MAX_LEN]       = 16'hFFFF;
    program_regs();
    add_item(payload_item(8'h01));                          // frame opened before the writes
    add_item(payload_item(8'hFE));
    add_item(header_item(8'hFF, 8'h00, 16'h0001, 16'hFFFF, 17'd65545)); // largest frame
    add_item(payload_item(8'h55));
    add_item(header_item(8'hFF, 8'hFF, 16'hFFFE, 16'hFFFF, 17'd65544));
    add_item(header_item(8'hFF, 8'h80, 16'h0000, 16'd0, 17'd65545));
    add_item(header_item(8'hFF, 8'h7F, 16'h8001, 16'd1, 17'd11));
    add_item(payload_item(8'h80));
    settle(4);

    // random, extreme registers; receiver holds off once to back up the input
    queue_random(110);
    pressure_req = 1'b1;
    settle(4);

    // random registers, small length limit
    for (int i = 0; i < 7; i++) reg_plan[i] = 16'($urandom_range(0, 65535));
    reg_plan[REG_MAX_LEN] = 16'($urandom_range(3, 30));
    program_regs();
    queue_random(110);
    settle(4);

    // zero length limit, two type codes equal
    for (int i = 0; i < 7; i++) reg_plan[i] = 16'($urandom_range(0, 65535));
    reg_plan[REG_KIND_RESPONSE] = reg_plan[REG_KIND_REQUEST];
    reg_plan[REG_MAX_LEN] = 16'd0;
    program_regs();
    queue_random(100);
    settle(4);

    // back to defaults, full rate on both sides
    plan_defaults();
    program_regs();
    quiet = 1'b1;
    queue_random(100);
    settle(8);

    if (error_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // driver: presents pending items, holds each until the block takes it
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) begin
        encode_transaction(on_wire);
        items_accepted++;
      end
      if (!(push && full)) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 4);
          push <= 1'b0;
        end else if (pending_items.size() != 0) begin
          on_wire = pending_items.pop_front();
          push            <= 1'b1;
          mode            <= on_wire.mode;
          frame_version   <= on_wire.version;
          frame_kind      <= on_wire.kind;
          sequence_number <= on_wire.seq;
          payload_count   <= on_wire.count;
          capacity        <= on_wire.cap;
          data_byte       <= on_wire.data;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // monitor: checks each popped result against the oldest expectation
  frame_out_t want;
  int  pop_gap = 0;
  int  hold_left = 0;
  bit  pressure_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected result transaction: out_byte %0h status %0d", out_byte, status);
          error_count++;
        end else begin
          want = frame_bytes_due.pop_front();
          check_field("out_byte", 17'(want.octet), 17'(out_byte));
          check_field("byte_valid", 17'(want.valid), 17'(byte_valid));
          check_field("status", 17'(want.code), 17'(status));
          check_field("last", 17'(want.tail), 17'(last));
          check_field("encoded_total", want.total, encoded_total);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop_gap = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: a run with no transaction for too long is hung
  int stalled_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/fec_pkg.sv
sv/fec_front.sv
sv/fec_queue.sv
sv/fec_back.sv
sv/frame_encoder_crc16_core.sv
test/tb_frame_encoder_crc16_core.sv
